@@ rtl/lshc_pkg.sv @@
// Shared types and constants for the log-scaled hue colormap unit.
// Holds the channel payload structs, register indexes and the log2 mantissa table.
// No dependencies.
package lshc_pkg;

   // register indexes on the csr channel
   localparam logic [3:0] CSR_CLAMP_LIMIT = 4'd0;
   localparam logic [3:0] CSR_HUE_GAIN    = 4'd1;

   localparam logic [15:0] CLAMP_LIMIT_RESET = 16'hFFFF;
   localparam logic [15:0] HUE_GAIN_RESET    = 16'd1536;

   // hue wheel ramps, one per sixth
   localparam logic [7:0] SEG_RED_TO_YELLOW    = 8'd0;
   localparam logic [7:0] SEG_YELLOW_TO_GREEN  = 8'd1;
   localparam logic [7:0] SEG_GREEN_TO_CYAN    = 8'd2;
   localparam logic [7:0] SEG_CYAN_TO_BLUE     = 8'd3;
   localparam logic [7:0] SEG_BLUE_TO_MAGENTA  = 8'd4;
   localparam logic [7:0] SEG_MAGENTA_TO_RED   = 8'd5;

   typedef struct packed {
      logic [19:0] pixel_index;
   } req_meta_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [19:0] out_index;
   } rsp_data_type;

   // round(2048 * log2(1 + k/32)), k = 0..32
   function automatic logic [11:0] log_mant(input logic [5:0] k);
      logic [11:0] v;
      case (k)
         6'd0:  v = 12'd0;
         6'd1:  v = 12'd91;
         6'd2:  v = 12'd179;
         6'd3:  v = 12'd265;
         6'd4:  v = 12'd348;
         6'd5:  v = 12'd429;
         6'd6:  v = 12'd508;
         6'd7:  v = 12'd585;
         6'd8:  v = 12'd659;
         6'd9:  v = 12'd732;
         6'd10: v = 12'd803;
         6'd11: v = 12'd873;
         6'd12: v = 12'd941;
         6'd13: v = 12'd1007;
         6'd14: v = 12'd1072;
         6'd15: v = 12'd1136;
         6'd16: v = 12'd1198;
         6'd17: v = 12'd1259;
         6'd18: v = 12'd1319;
         6'd19: v = 12'd1377;
         6'd20: v = 12'd1435;
         6'd21: v = 12'd1491;
         6'd22: v = 12'd1546;
         6'd23: v = 12'd1600;
         6'd24: v = 12'd1653;
         6'd25: v = 12'd1706;
         6'd26: v = 12'd1757;
         6'd27: v = 12'd1808;
         6'd28: v = 12'd1857;
         6'd29: v = 12'd1906;
         6'd30: v = 12'd1954;
         6'd31: v = 12'd2001;
         6'd32: v = 12'd2048;
         default: v = 12'd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/log_scaled_hue_colormap_unit.sv @@
// Top level of the log-scaled hue colormap: five-stage pipeline, sample in, RGB out.
// Depends on lshc_pkg (payload structs, register indexes, log2 mantissa table).
//
// Usage:
//   req channel: one field sample (req_sample) plus its pixel position
//   (req_data) per transfer, valid/stall handshake, accepted when
//   req_valid is high and req_stall is low.
//   rsp channel: one RGB pixel with the same position per input transfer,
//   in order, accepted when rsp_valid is high and rsp_stall is low.
//   csr channel: valid/ready writes of clamp_limit (index 0) and hue_gain
//   (index 1); csr_ready is always high, other indexes are dropped.
//   Write registers only while the pipeline is empty.
// Timing:
//   An accepted input passes the five register stages in order
//   (clamp, leading-one normalize, table interpolate, gain multiply, ramp select);
//   throughput is one pixel per clock while rsp_stall is low.
// Reset (synchronous, active high) empties the pipeline and loads
//   clamp_limit = 65535 and hue_gain = 1536.
// Stall: when rsp_stall holds the output stage, earlier stages keep
//   filling until each holds an item; then req_stall rises. Nothing is
//   dropped or repeated.
module log_scaled_hue_colormap_unit #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   input  lshc_pkg::req_meta_type   req_data,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lshc_pkg::rsp_data_type   rsp_data,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [3:0]               csr_index,
   input  logic [15:0]              csr_wdata
);

   localparam int CW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

   // configuration
   logic [15:0] clamp_limit_ff, clamp_limit_in;
   logic [15:0] hue_gain_ff, hue_gain_in;

   assign csr_ready = 1'b1;

   always_comb begin
      clamp_limit_in = clamp_limit_ff;
      hue_gain_in    = hue_gain_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lshc_pkg::CSR_CLAMP_LIMIT: clamp_limit_in = csr_wdata;
            lshc_pkg::CSR_HUE_GAIN:    hue_gain_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_limit_ff <= lshc_pkg::CLAMP_LIMIT_RESET;
         hue_gain_ff    <= lshc_pkg::HUE_GAIN_RESET;
      end else begin
         clamp_limit_ff <= clamp_limit_in;
         hue_gain_ff    <= hue_gain_in;
      end
   end

   // stage valids and load enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_load, s2_load, s3_load, s4_load, s5_load;

   assign s5_load   = !s5_valid_ff || !rsp_stall;
   assign s4_load   = !s4_valid_ff || s5_load;
   assign s3_load   = !s3_valid_ff || s4_load;
   assign s2_load   = !s2_valid_ff || s3_load;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= req_valid;
         if (s2_load) s2_valid_ff <= s1_valid_ff;
         if (s3_load) s3_valid_ff <= s2_valid_ff;
         if (s4_load) s4_valid_ff <= s3_valid_ff;
         if (s5_load) s5_valid_ff <= s4_valid_ff;
      end
   end

   // stage 1: zero test, clamp, x = clamped + 1
   logic [CW-1:0] s1_sample_ext, s1_limit_ext;
   logic [15:0]   s1_clamped;
   logic [16:0]   s1_x_in, s1_x_ff;
   logic          s1_zero_ff;
   logic [19:0]   s1_index_ff;

   always_comb begin
      s1_sample_ext = CW'(req_sample);
      s1_limit_ext  = CW'(clamp_limit_ff);
      s1_clamped    = (s1_sample_ext > s1_limit_ext) ? clamp_limit_ff : s1_sample_ext[15:0];
      s1_x_in       = {1'b0, s1_clamped} + 17'd1;
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_x_ff     <= s1_x_in;
         s1_zero_ff  <= (req_sample == '0);
         s1_index_ff <= req_data.pixel_index;
      end
   end

   // stage 2: leading-one position and normalize
   logic [4:0]  s2_exp_in, s2_exp_ff;
   logic [16:0] s2_norm;
   logic [4:0]  s2_idx_ff;
   logic [5:0]  s2_rem_ff;
   logic        s2_zero_ff;
   logic [19:0] s2_index_ff;

   always_comb begin
      s2_exp_in = 5'd0;
      for (int i = 1; i < 17; i++) begin
         if (s1_x_ff[i]) s2_exp_in = 5'(i);
      end
      s2_norm = s1_x_ff << (5'd16 - s2_exp_in);
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_exp_ff   <= s2_exp_in;
         s2_idx_ff   <= s2_norm[15:11];
         s2_rem_ff   <= s2_norm[10:5];
         s2_zero_ff  <= s1_zero_ff;
         s2_index_ff <= s1_index_ff;
      end
   end

   // stage 3: mantissa table with linear interpolation, Q5.11 log
   logic [11:0] s3_lo, s3_hi;
   logic [6:0]  s3_diff;
   logic [12:0] s3_prod;
   logic [15:0] s3_log_in, s3_log_ff;
   logic        s3_zero_ff;
   logic [19:0] s3_index_ff;

   always_comb begin
      s3_lo     = lshc_pkg::log_mant({1'b0, s2_idx_ff});
      s3_hi     = lshc_pkg::log_mant({1'b0, s2_idx_ff} + 6'd1);
      s3_diff   = 7'(s3_hi - s3_lo);
      s3_prod   = 13'(s3_diff * s2_rem_ff);
      s3_log_in = {s2_exp_ff, 11'd0} + 16'(s3_lo) + 16'(s3_prod[12:6]);
   end

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_log_ff   <= s3_log_in;
         s3_zero_ff  <= s2_zero_ff;
         s3_index_ff <= s2_index_ff;
      end
   end

   // stage 4: hue position = log * gain, Q8.23 (fits in 31 bits)
   logic [31:0] s4_prod;
   logic [30:0] s4_pos_ff;
   logic        s4_zero_ff;
   logic [19:0] s4_index_ff;

   assign s4_prod = s3_log_ff * hue_gain_ff;

   always_ff @(posedge clock) begin
      if (s4_load) begin
         s4_pos_ff   <= s4_prod[30:0];
         s4_zero_ff  <= s3_zero_ff;
         s4_index_ff <= s3_index_ff;
      end
   end

   // stage 5: ramp select; x*255 done as (x << 8) - x
   logic [7:0]  s5_seg;
   logic [22:0] s5_frac;
   logic [30:0] s5_rise_prod;
   logic [23:0] s5_rest;
   logic [31:0] s5_fall_prod;
   logic [7:0]  s5_rise, s5_fall;
   logic [7:0]  s5_r, s5_g, s5_b;
   lshc_pkg::rsp_data_type s5_data_ff;

   always_comb begin
      s5_seg       = s4_pos_ff[30:23];
      s5_frac      = s4_pos_ff[22:0];
      s5_rise_prod = {s5_frac, 8'd0} - {8'd0, s5_frac};
      s5_rise      = s5_rise_prod[30:23];
      s5_rest      = 24'h800000 - {1'b0, s5_frac};
      s5_fall_prod = {s5_rest, 8'd0} - {8'd0, s5_rest};
      s5_fall      = s5_fall_prod[30:23];
      case (s5_seg)
         lshc_pkg::SEG_RED_TO_YELLOW: begin
            s5_r = 8'd255;  s5_g = s5_rise; s5_b = 8'd0;
         end
         lshc_pkg::SEG_YELLOW_TO_GREEN: begin
            s5_r = s5_fall; s5_g = 8'd255;  s5_b = 8'd0;
         end
         lshc_pkg::SEG_GREEN_TO_CYAN: begin
            s5_r = 8'd0;    s5_g = 8'd255;  s5_b = s5_rise;
         end
         lshc_pkg::SEG_CYAN_TO_BLUE: begin
            s5_r = 8'd0;    s5_g = s5_fall; s5_b = 8'd255;
         end
         lshc_pkg::SEG_BLUE_TO_MAGENTA: begin
            s5_r = s5_rise; s5_g = 8'd0;    s5_b = 8'd255;
         end
         lshc_pkg::SEG_MAGENTA_TO_RED: begin
            s5_r = 8'd255;  s5_g = 8'd0;    s5_b = s5_fall;
         end
         default: begin
            // past the end of the wheel: pinned at red
            s5_r = 8'd255;  s5_g = 8'd0;    s5_b = 8'd0;
         end
      endcase
      if (s4_zero_ff) begin
         s5_r = 8'd0;
         s5_g = 8'd0;
         s5_b = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_load) begin
         s5_data_ff.red       <= s5_r;
         s5_data_ff.green     <= s5_g;
         s5_data_ff.blue      <= s5_b;
         s5_data_ff.out_index <= s4_index_ff;
      end
   end

   assign rsp_valid = s5_valid_ff;
   assign rsp_data  = s5_data_ff;

   // checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted request did not enter stage 1");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && s5_valid_ff && rsp_stall |=> s4_valid_ff && $stable(s4_pos_ff))
      else $error("stage 4 item lost under output stall");

   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_exp_ff <= 5'd16)
      else $error("leading-one position out of range");

   a_log_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_log_ff <= 16'd32768)
      else $error("log value exceeds log2 of 65536");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !s1_valid_ff && !s5_valid_ff && !rsp_valid)
      else $error("pipeline not empty after reset");

endmodule

@@ tb/hue_pixel_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for log_scaled_hue_colormap_unit: follows the req, rsp and csr channels.
// Predicts each pixel from its own copy of the registers and compares every field.
// Depends on lshc_pkg for the payload structs, register indexes and ramp codes.
module hue_pixel_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   input  lshc_pkg::req_meta_type   req_data,

   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  lshc_pkg::rsp_data_type   rsp_data,

   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [3:0]               csr_index,
   input  logic [15:0]              csr_wdata,

   output int                       error_count,
   output int                       pending,
   output int                       pixels_checked
);

   localparam int FRAC_W = 23;

   logic [15:0] limit_q;
   logic [15:0] gain_q;
   logic [11:0] mant_tab [0:32];
   lshc_pkg::rsp_data_type colors_due [$];
   int errs = 0;
   int checked = 0;

   // log2(1 + k/32) in units of 1/2048
   initial begin
      mant_tab = '{12'd0,    12'd91,   12'd179,  12'd265,  12'd348,  12'd429,  12'd508,
                   12'd585,  12'd659,  12'd732,  12'd803,  12'd873,  12'd941,  12'd1007,
                   12'd1072, 12'd1136, 12'd1198, 12'd1259, 12'd1319, 12'd1377, 12'd1435,
                   12'd1491, 12'd1546, 12'd1600, 12'd1653, 12'd1706, 12'd1757, 12'd1808,
                   12'd1857, 12'd1906, 12'd1954, 12'd2001, 12'd2048};
   end

   function automatic lshc_pkg::rsp_data_type color_of(input logic [SAMPLE_BITS-1:0] smp,
                                                      input logic [19:0] pidx);
      lshc_pkg::rsp_data_type px;
      logic [63:0] x, frac32, lo, hi, lg, pos, seg, f, rise, fall;
      int unsigned e;
      int ti;
      logic [5:0] rem;
      px = '0;
      px.out_index = pidx;
      if (smp != '0) begin
         x = 64'(smp);
         if (x > 64'(limit_q)) x = 64'(limit_q);
         x = x + 64'd1;
         e = 0;
         while (e < 40 && (x >> (e + 1)) != 64'd0) e++;
         if (e > 32) e = 32;
         frac32 = (x << (32 - e)) & 64'hFFFF_FFFF;
         ti = int'(frac32[31:27]);
         rem = frac32[26:21];
         lo = 64'(mant_tab[ti]);
         hi = 64'(mant_tab[ti + 1]);
         lg = (64'(e) << 11) + lo + (((hi - lo) * 64'(rem)) >> 6);
         pos = lg * 64'(gain_q);
         seg = pos >> FRAC_W;
         f = pos & ((64'd1 << FRAC_W) - 64'd1);
         rise = (f * 64'd255) >> FRAC_W;
         fall = (((64'd1 << FRAC_W) - f) * 64'd255) >> FRAC_W;
         case (seg)
            lshc_pkg::SEG_RED_TO_YELLOW: begin
               px.red = 8'd255; px.green = rise[7:0]; px.blue = 8'd0;
            end
            lshc_pkg::SEG_YELLOW_TO_GREEN: begin
               px.red = fall[7:0]; px.green = 8'd255; px.blue = 8'd0;
            end
            lshc_pkg::SEG_GREEN_TO_CYAN: begin
               px.red = 8'd0; px.green = 8'd255; px.blue = rise[7:0];
            end
            lshc_pkg::SEG_CYAN_TO_BLUE: begin
               px.red = 8'd0; px.green = fall[7:0]; px.blue = 8'd255;
            end
            lshc_pkg::SEG_BLUE_TO_MAGENTA: begin
               px.red = rise[7:0]; px.green = 8'd0; px.blue = 8'd255;
            end
            lshc_pkg::SEG_MAGENTA_TO_RED: begin
               px.red = 8'd255; px.green = 8'd0; px.blue = fall[7:0];
            end
            // past the end of the wheel: pinned at red
            default: begin
               px.red = 8'd255; px.green = 8'd0; px.blue = 8'd0;
            end
         endcase
      end
      return px;
   endfunction

   task automatic check_field(input string name, input logic [19:0] want,
                              input logic [19:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      lshc_pkg::rsp_data_type want;
      if (reset) begin
         limit_q = lshc_pkg::CLAMP_LIMIT_RESET;
         gain_q  = lshc_pkg::HUE_GAIN_RESET;
         colors_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (colors_due.size() == 0) begin
               $error("pixel transfer with nothing expected: index %0d", rsp_data.out_index);
               errs++;
            end else begin
               want = colors_due.pop_front();
               check_field("red", 20'(want.red), 20'(rsp_data.red));
               check_field("green", 20'(want.green), 20'(rsp_data.green));
               check_field("blue", 20'(want.blue), 20'(rsp_data.blue));
               check_field("out_index", want.out_index, rsp_data.out_index);
               checked++;
            end
         end
         // predicted with the settings in force before any write on this edge
         if (req_valid && !req_stall)
            colors_due.push_back(color_of(req_sample, req_data.pixel_index));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lshc_pkg::CSR_CLAMP_LIMIT: limit_q = csr_wdata;
               lshc_pkg::CSR_HUE_GAIN:    gain_q  = csr_wdata;
               default: ;
            endcase
         end
      end
      pending        <= colors_due.size();
      error_count    <= errs;
      pixels_checked <= checked;
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for log_scaled_hue_colormap_unit.
// Drives samples, register writes and output back-pressure; hue_pixel_checker does the compare.
module tb;

   localparam int SAMPLE_W   = 16;
   localparam int QUIET_MAX  = 2000;
   localparam int RAND_ITEMS = 80;
   localparam logic [3:0] CSR_FIRST_UNUSED = lshc_pkg::CSR_HUE_GAIN + 4'd1;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [SAMPLE_W-1:0]      req_sample = '0;
   lshc_pkg::req_meta_type   req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   lshc_pkg::rsp_data_type   rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [3:0]               csr_index = '0;
   logic [15:0]              csr_wdata = '0;

   int error_count, pending, pixels_checked;
   int items_sent = 0;
   int settings_used = 0;
   int quiet = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;

   always #10 clock = ~clock;

   log_scaled_hue_colormap_unit #(.SAMPLE_BITS(SAMPLE_W)) uut (
      .clock, .reset,
      .req_valid, .req_stall, .req_sample, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   hue_pixel_checker #(.SAMPLE_BITS(SAMPLE_W)) scoreboard (
      .clock, .reset,
      .req_valid, .req_stall, .req_sample, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .error_count, .pending, .pixels_checked
   );

   // output back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
         $display("timeout: no transfer for %0d cycles", QUIET_MAX);
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic [19:0] pidx);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample <= smp;
      req_data.pixel_index <= pidx;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // hold off until every pixel in flight has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [3:0] ix, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= ix;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_colormap(input logic [15:0] lim, input logic [15:0] gn);
      wait_drained();
      write_reg(lshc_pkg::CSR_CLAMP_LIMIT, lim);
      write_reg(lshc_pkg::CSR_HUE_GAIN, gn);
      // unmapped index must leave both registers alone
      write_reg(4'($urandom_range(15, CSR_FIRST_UNUSED)), 16'($urandom));
      settings_used++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [15:0] lim);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return SAMPLE_W'($urandom_range(1, 255));
         4:       return SAMPLE_W'(lim);
         5:       return SAMPLE_W'(lim) + SAMPLE_W'(1);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] lim, gn;
      int ph, i;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults after reset: small values, wheel saturation at the top
      push_sample(16'd0, 20'd0);
      push_sample(16'd1, 20'hFFFFF);
      push_sample(16'd2, 20'd1);
      push_sample(16'd3, 20'h55555);
      push_sample(16'd255, 20'hAAAAA);
      push_sample(16'd256, 20'd7);
      push_sample(16'd32768, 20'h80000);
      push_sample(16'hFFFE, 20'h7FFFF);
      push_sample(16'hFFFF, 20'hFFFFF);

      // one sixth per octave: ramps yellow-to-green to magenta-to-red in turn, then past the wheel
      set_colormap(16'hFFFF, 16'd4096);
      push_sample(16'd1, 20'd10);
      push_sample(16'd3, 20'd11);
      push_sample(16'd7, 20'd12);
      push_sample(16'd15, 20'd13);
      push_sample(16'd31, 20'd14);
      push_sample(16'd63, 20'd15);
      push_sample(16'd0, 20'd16);

      // zero clamp limit
      set_colormap(16'd0, 16'd4096);
      push_sample(16'd1, 20'd20);
      push_sample(16'hFFFF, 20'd21);
      push_sample(16'd0, 20'd22);

      // zero and full gain
      set_colormap(16'hFFFF, 16'd0);
      push_sample(16'd9, 20'd30);
      push_sample(16'hFFFF, 20'd31);
      set_colormap(16'hFFFF, 16'hFFFF);
      push_sample(16'd1, 20'd40);
      push_sample(16'hFFFF, 20'd41);

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       begin lim = lshc_pkg::CLAMP_LIMIT_RESET; gn = lshc_pkg::HUE_GAIN_RESET; end
            1:       begin lim = 16'd1; gn = 16'hFFFF; end
            2:       begin
               lim = 16'($urandom_range(2, 65534));
               gn  = 16'($urandom_range(1, 65534));
            end
            3:       begin lim = 16'd255; gn = 16'd0; end
            4:       begin lim = 16'd0; gn = 16'd4096; end
            5:       begin
               lim = 16'($urandom_range(1, 65535));
               gn  = 16'($urandom_range(0, 8192));
            end
            6:       begin lim = 16'd4095; gn = 16'd2048; end
            default: begin lim = 16'hFFFF; gn = 16'($urandom_range(1024, 4096)); end
         endcase
         idle_on = (ph != 7);
         set_colormap(lim, gn);
         for (i = 0; i < RAND_ITEMS; i++) begin
            push_sample(pick_sample(lim), 20'($urandom));
            if (ph == 2 && i == RAND_ITEMS / 2) wait_drained();
         end
      end

      wait_drained();
      $display("%0d samples sent, %0d pixels checked, %0d register settings", items_sent,
               pixels_checked, settings_used);
      $display("covered black, clamped, zero and full gain, every ramp and wheel saturation");
      if (error_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
